>>> rtl/ght_pkg.sv
// Shared constants and helpers for the generational handle table.
package ght_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int LEASE_BITS_DEF = 16;
  localparam int SLOT_FW        = 9;
  localparam int GEN_W          = 32;
  localparam int KEY_W          = 32;
  localparam int REV_W          = 64;

  localparam logic [2:0] MODE_REGISTER  = 3'd0;
  localparam logic [2:0] MODE_BORROW    = 3'd1;
  localparam logic [2:0] MODE_RESOLVE   = 3'd2;
  localparam logic [2:0] MODE_RELEASE   = 3'd3;
  localparam logic [2:0] MODE_REL_LEASE = 3'd4;
  localparam logic [2:0] MODE_CLEAR     = 3'd5;
  localparam logic [2:0] MODE_DESTROYED = 3'd6;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OBJECT    = 3'd1;
  localparam logic [2:0] ERR_HANDLE    = 3'd2;
  localparam logic [2:0] ERR_GEN       = 3'd3;
  localparam logic [2:0] ERR_STALE     = 3'd4;
  localparam logic [2:0] ERR_NO_LEASE  = 3'd5;
  localparam logic [2:0] ERR_LEASE_OVF = 3'd6;
  localparam logic [2:0] ERR_FULL      = 3'd7;

  localparam int FL_OCC   = 0;
  localparam int FL_ANCH  = 1;
  localparam int FL_ALIVE = 2;

  function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
    next_gen = (g == {GEN_W{1'b1}}) ? {{(GEN_W-1){1'b0}}, 1'b1} : g + 1'b1;
  endfunction

endpackage

>>> rtl/ght_slot_mem.sv
// Slot entry memory: one write port, one registered read port.
module ght_slot_mem
  import ght_pkg::*;
#(
  parameter int DEPTH = SLOT_COUNT_DEF,
  parameter int W     = 83,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ght_free_stack.sv
// Free slot stack storage: one write port, one registered read port.
module ght_free_stack
  import ght_pkg::*;
#(
  parameter int DEPTH = SLOT_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] stk [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      stk[waddr] <= wdata;
    end
    rdata <= stk[raddr];
  end

endmodule

>>> rtl/generational_handle_table.sv
// Generational handle table: top level with the operation sequencer.
// One item is in work at a time. Register, borrow and object-destroyed scan the
// slots used so far through the single read port of the slot memory, one slot
// per cycle; register and borrow may also pop a freed slot from the free stack.
// Resolve, release and lease release pass through a handle check state; clear
// all and unknown modes go straight to the result. A result waits in the output
// register until taken; the next item is accepted once that result is loaded.
// Slots beyond the used mark are never read, so no clearing pass follows reset.
module generational_handle_table
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int LEASE_BITS = LEASE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,   // first_generation
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // object_id, object_alive, handle_slot, handle_generation
  input  logic [2:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // out_slot, out_generation, out_object_id, revision, live_count
  output logic [3:0]   out_tuser   // succeeded, error_code
);

  localparam int SW   = $clog2(SLOT_COUNT);
  localparam int CW   = $clog2(SLOT_COUNT + 1);
  localparam int CMPW = (CW > SLOT_FW) ? CW : SLOT_FW;
  localparam int LB   = LEASE_BITS;
  localparam int EW   = KEY_W + GEN_W + LB + 3;
  localparam int GLO  = KEY_W;
  localparam int LLO  = KEY_W + GEN_W;
  localparam int FLO  = KEY_W + GEN_W + LB;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_POPW, S_ALLOC, S_HCHK, S_RESP
  } state_t;

  state_t            state_r;
  logic [2:0]        mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [SLOT_FW-1:0] hslot_r;
  logic [GEN_W-1:0]  hgen_r;
  logic [CW-1:0]     scan_idx_r;
  logic              rd_vld_r;
  logic [SW-1:0]     rd_idx_r;
  logic [SW-1:0]     idx_r;
  logic [CW-1:0]     free_top_r;
  logic [CW-1:0]     mark_r;
  logic [CW-1:0]     occ_r;
  logic [GEN_W-1:0]  dom_r;
  logic [REV_W-1:0]  rev_r;
  logic              res_ok_r;
  logic [2:0]        res_err_r;
  logic [SLOT_FW-1:0] res_slot_r;
  logic [GEN_W-1:0]  res_gen_r;
  logic [KEY_W-1:0]  res_obj_r;
  logic              out_valid_r;
  logic [151:0]      out_data_r;
  logic [3:0]        out_user_r;

  state_t            state_nxt;
  logic [2:0]        mode_nxt;
  logic [KEY_W-1:0]  key_nxt;
  logic [SLOT_FW-1:0] hslot_nxt;
  logic [GEN_W-1:0]  hgen_nxt;
  logic [CW-1:0]     scan_idx_nxt;
  logic              rd_vld_nxt;
  logic [SW-1:0]     rd_idx_nxt;
  logic [SW-1:0]     idx_nxt;
  logic [CW-1:0]     free_top_nxt;
  logic [CW-1:0]     mark_nxt;
  logic [CW-1:0]     occ_nxt;
  logic [GEN_W-1:0]  dom_nxt;
  logic              rev_bump;
  logic              res_ok_nxt;
  logic [2:0]        res_err_nxt;
  logic [SLOT_FW-1:0] res_slot_nxt;
  logic [GEN_W-1:0]  res_gen_nxt;
  logic [KEY_W-1:0]  res_obj_nxt;

  logic              mem_we;
  logic [SW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;
  logic [SW-1:0]     mem_raddr;
  logic [EW-1:0]     mem_rdata;
  logic              fs_we;
  logic [SW-1:0]     fs_waddr;
  logic [SW-1:0]     fs_wdata;
  logic [SW-1:0]     fs_raddr;
  logic [SW-1:0]     fs_rdata;

  logic [KEY_W-1:0]  e_key;
  logic [GEN_W-1:0]  e_gen;
  logic [LB-1:0]     e_lease;
  logic [2:0]        e_fl;
  logic [CMPW-1:0]   hslot_w;
  logic [CMPW-1:0]   hslot_dec;
  logic [CMPW-1:0]   mark_w;
  logic [CMPW-1:0]   in_slot_dec;
  logic [CMPW-1:0]   rd_slot_w;
  logic [CMPW-1:0]   idx_slot_w;
  logic [CMPW-1:0]   mark_slot_w;
  logic [CMPW-1:0]   occ_w;
  logic [LB-1:0]     lease_dec;
  logic              in_xfer;
  logic              out_load;
  logic              issue;
  logic              key_hit;
  logic [KEY_W-1:0]  obj_live;

  assign e_key   = mem_rdata[KEY_W-1:0];
  assign e_gen   = mem_rdata[GLO +: GEN_W];
  assign e_lease = mem_rdata[LLO +: LB];
  assign e_fl    = mem_rdata[FLO +: 3];
  assign lease_dec = e_lease - 1'b1;
  assign obj_live  = e_fl[FL_ALIVE] ? e_key : '0;

  assign hslot_w     = CMPW'(hslot_r);
  assign hslot_dec   = hslot_w - 1'b1;
  assign mark_w      = CMPW'(mark_r);
  assign in_slot_dec = CMPW'(in_tdata[41:33]) - 1'b1;
  assign rd_slot_w   = CMPW'(rd_idx_r) + 1'b1;
  assign idx_slot_w  = CMPW'(idx_r) + 1'b1;
  assign mark_slot_w = mark_w + 1'b1;
  assign occ_w       = CMPW'(occ_r);

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;
  assign issue     = (scan_idx_r < mark_r);
  assign key_hit   = rd_vld_r && e_fl[FL_OCC] && (e_key == key_r);

  ght_slot_mem #(.DEPTH(SLOT_COUNT), .W(EW), .AW(SW)) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ght_free_stack #(.DEPTH(SLOT_COUNT), .AW(SW)) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    hslot_nxt    = hslot_r;
    hgen_nxt     = hgen_r;
    scan_idx_nxt = scan_idx_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    idx_nxt      = idx_r;
    free_top_nxt = free_top_r;
    mark_nxt     = mark_r;
    occ_nxt      = occ_r;
    dom_nxt      = dom_r;
    rev_bump     = 1'b0;
    res_ok_nxt   = res_ok_r;
    res_err_nxt  = res_err_r;
    res_slot_nxt = res_slot_r;
    res_gen_nxt  = res_gen_r;
    res_obj_nxt  = res_obj_r;
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_r;
    mem_wdata    = mem_rdata;
    mem_raddr    = scan_idx_r[SW-1:0];
    fs_we        = 1'b0;
    fs_waddr     = free_top_r[SW-1:0];
    fs_wdata     = idx_r;
    fs_raddr     = '0;

    if (cfg_valid) begin
      dom_nxt = (cfg_data == '0) ? 32'd1 : cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        mem_raddr = in_slot_dec[SW-1:0];
        if (in_xfer) begin
          mode_nxt     = in_tuser;
          key_nxt      = in_tdata[31:0];
          hslot_nxt    = in_tdata[41:33];
          hgen_nxt     = in_tdata[73:42];
          scan_idx_nxt = '0;
          res_ok_nxt   = 1'b0;
          res_err_nxt  = ERR_NONE;
          res_slot_nxt = '0;
          res_gen_nxt  = '0;
          res_obj_nxt  = '0;
          case (in_tuser)
            MODE_REGISTER, MODE_BORROW: begin
              if (!in_tdata[32]) begin
                res_err_nxt = ERR_OBJECT;
                state_nxt   = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            MODE_DESTROYED: state_nxt = S_SCAN;
            MODE_RESOLVE, MODE_RELEASE, MODE_REL_LEASE: state_nxt = S_HCHK;
            MODE_CLEAR: begin
              free_top_nxt = '0;
              mark_nxt     = '0;
              occ_nxt      = '0;
              dom_nxt      = next_gen(dom_r);
              rev_bump     = 1'b1;
              res_ok_nxt   = 1'b1;
              state_nxt    = S_RESP;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end

      S_SCAN: begin
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          rd_vld_nxt   = 1'b1;
          rd_idx_nxt   = scan_idx_r[SW-1:0];
        end
        if (mode_r == MODE_DESTROYED) begin
          if (key_hit) begin
            mem_we    = 1'b1;
            mem_wdata[FLO + FL_ALIVE] = 1'b0;
          end
          if (!issue && !rd_vld_r) begin
            res_ok_nxt = 1'b1;
            state_nxt  = S_RESP;
          end
        end else if (key_hit && e_fl[FL_ALIVE]) begin
          res_slot_nxt = rd_slot_w[SLOT_FW-1:0];
          res_gen_nxt  = e_gen;
          state_nxt    = S_RESP;
          if (mode_r == MODE_REGISTER) begin
            mem_we = 1'b1;
            mem_wdata[FLO + FL_ANCH] = 1'b1;
            res_ok_nxt  = 1'b1;
            res_obj_nxt = key_r;
          end else if (e_lease == {LB{1'b1}}) begin
            res_err_nxt = ERR_LEASE_OVF;
          end else begin
            mem_we = 1'b1;
            mem_wdata[LLO +: LB] = e_lease + 1'b1;
            res_ok_nxt  = 1'b1;
            res_obj_nxt = key_r;
          end
        end else if (!issue && !rd_vld_r) begin
          if (free_top_r != '0) begin
            free_top_nxt = free_top_r - 1'b1;
            fs_raddr     = free_top_nxt[SW-1:0];
            state_nxt    = S_POPW;
          end else if (mark_r < CW'(SLOT_COUNT)) begin
            mem_we    = 1'b1;
            mem_waddr = mark_r[SW-1:0];
            mem_wdata = {1'b1, (mode_r == MODE_REGISTER), 1'b1,
                         (mode_r == MODE_BORROW) ? LB'(1) : LB'(0), dom_r, key_r};
            mark_nxt  = mark_r + 1'b1;
            occ_nxt   = occ_r + 1'b1;
            rev_bump  = 1'b1;
            res_ok_nxt   = 1'b1;
            res_obj_nxt  = key_r;
            res_slot_nxt = mark_slot_w[SLOT_FW-1:0];
            res_gen_nxt  = dom_r;
            state_nxt    = S_RESP;
          end else begin
            res_err_nxt = ERR_FULL;
            state_nxt   = S_RESP;
          end
        end
      end

      S_POPW: begin
        mem_raddr = fs_rdata;
        idx_nxt   = fs_rdata;
        state_nxt = S_ALLOC;
      end

      S_ALLOC: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = {1'b1, (mode_r == MODE_REGISTER), 1'b1,
                     (mode_r == MODE_BORROW) ? LB'(1) : LB'(0), e_gen, key_r};
        occ_nxt   = occ_r + 1'b1;
        rev_bump  = 1'b1;
        res_ok_nxt   = 1'b1;
        res_obj_nxt  = key_r;
        res_slot_nxt = idx_slot_w[SLOT_FW-1:0];
        res_gen_nxt  = e_gen;
        state_nxt    = S_RESP;
      end

      S_HCHK: begin
        idx_nxt      = hslot_dec[SW-1:0];
        mem_waddr    = hslot_dec[SW-1:0];
        fs_wdata     = hslot_dec[SW-1:0];
        res_slot_nxt = hslot_r;
        res_gen_nxt  = hgen_r;
        state_nxt    = S_RESP;
        if (hslot_r == '0 || hgen_r == '0 || hslot_w > mark_w) begin
          res_err_nxt = ERR_HANDLE;
        end else if (e_gen != hgen_r) begin
          res_err_nxt = ERR_GEN;
        end else if (mode_r == MODE_RESOLVE) begin
          if (!e_fl[FL_OCC]) begin
            res_err_nxt = ERR_STALE;
          end else if (!e_fl[FL_ALIVE]) begin
            res_err_nxt = ERR_OBJECT;
          end else begin
            res_ok_nxt  = 1'b1;
            res_obj_nxt = e_key;
          end
        end else if (mode_r == MODE_RELEASE && !e_fl[FL_OCC]) begin
          res_err_nxt = ERR_STALE;
        end else if (mode_r == MODE_REL_LEASE && (!e_fl[FL_OCC] || e_lease == '0)) begin
          res_err_nxt = ERR_NO_LEASE;
        end else begin
          res_ok_nxt  = 1'b1;
          res_obj_nxt = obj_live;
          mem_we      = 1'b1;
          if (mode_r == MODE_REL_LEASE && (lease_dec != '0 || e_fl[FL_ANCH])) begin
            mem_wdata[LLO +: LB] = lease_dec;
          end else begin
            mem_wdata = {3'b000, LB'(0), next_gen(e_gen), KEY_W'(0)};
            if (free_top_r < CW'(SLOT_COUNT)) begin
              fs_we        = 1'b1;
              free_top_nxt = free_top_r + 1'b1;
            end
            if (occ_r != '0) begin
              occ_nxt = occ_r - 1'b1;
            end
            rev_bump = 1'b1;
          end
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      free_top_r  <= '0;
      mark_r      <= '0;
      occ_r       <= '0;
      dom_r       <= 32'd1;
      rev_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= rd_vld_nxt;
      free_top_r <= free_top_nxt;
      mark_r     <= mark_nxt;
      occ_r      <= occ_nxt;
      dom_r      <= dom_nxt;
      if (rev_bump) begin
        rev_r <= (rev_r == {REV_W{1'b1}}) ? REV_W'(1) : rev_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    hslot_r    <= hslot_nxt;
    hgen_r     <= hgen_nxt;
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    idx_r      <= idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_err_r  <= res_err_nxt;
    res_slot_r <= res_slot_nxt;
    res_gen_r  <= res_gen_nxt;
    res_obj_r  <= res_obj_nxt;
    if (out_load) begin
      out_data_r <= {6'd0, occ_w[SLOT_FW-1:0], rev_r, res_obj_r, res_gen_r, res_slot_r};
      out_user_r <= {res_err_r, res_ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> rtl/ght_checker.sv
// Port-level checks for the generational handle table, bound to the top level.
module ght_checker
  import ght_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [151:0] out_tdata,
  input logic [3:0]   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer accepted while busy");

  a_ok_noerr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[3:1] == ERR_NONE)
    else $error("success with error code");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3:1] == ERR_FULL |-> out_tdata[40:0] == '0 && out_tdata[72:41] == '0)
    else $error("full result carries a handle");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> bench/tb_generational_handle_table.sv
// Testbench for generational_handle_table: directed and random handle operations vs a predictor.
`timescale 1ns / 100ps

module tb_generational_handle_table;
  import ght_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int unsigned LEASE_MAX = (1 << LEASE_BITS_DEF) - 1;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic        ok;
    logic [2:0]  err;
    logic [8:0]  slot;
    logic [31:0] gen;
    logic [31:0] key;
    logic [63:0] rev;
    logic [8:0]  live;
  } table_result_t;

  class handle_table_scoreboard;
    logic [31:0] key_of[SLOTS];
    logic [31:0] gen_of[SLOTS];
    int unsigned leases[SLOTS];
    bit occ[SLOTS];
    bit anch[SLOTS];
    bit alive[SLOTS];
    int unsigned free_list[SLOTS];
    int unsigned free_top, used_mark, live_total;
    logic [31:0] domain;
    logic [63:0] rev;
    table_result_t awaited[$];
    int mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        occ[i] = 0; anch[i] = 0; alive[i] = 0;
        key_of[i] = 0; gen_of[i] = 0; leases[i] = 0; free_list[i] = 0;
      end
      free_top = 0; used_mark = 0; live_total = 0;
      domain = 1; rev = 0; mismatches = 0;
    endfunction

    function void set_first_generation(logic [31:0] v);
      domain = (v != 0) ? v : 32'd1;
    endfunction

    function logic [31:0] gen_after(logic [31:0] g);
      return (g == 32'hFFFF_FFFF) ? 32'd1 : g + 32'd1;
    endfunction

    function void step_revision();
      rev = rev + 64'd1;
      if (rev == 0) rev = 64'd1;
    endfunction

    function void free_entry(int unsigned i);
      occ[i] = 0; anch[i] = 0; alive[i] = 0;
      leases[i] = 0; key_of[i] = 0;
      gen_of[i] = gen_after(gen_of[i]);
      if (free_top < SLOTS) begin
        free_list[free_top] = i;
        free_top++;
      end
      if (live_total > 0) live_total--;
      step_revision();
    endfunction

    function int find_live_key(logic [31:0] k);
      for (int i = 0; i < used_mark; i++)
        if (occ[i] && alive[i] && key_of[i] == k) return i;
      return -1;
    endfunction

    function void note_input(logic [2:0] mode, logic [31:0] k, logic live_obj,
                             logic [8:0] hslot, logic [31:0] hgen);
      table_result_t r;
      int f;
      int unsigned i;
      r = '0;
      if (mode == MODE_REGISTER || mode == MODE_BORROW) begin
        if (!live_obj) begin
          r.err = ERR_OBJECT;
        end else if ((f = find_live_key(k)) >= 0) begin
          i = f;
          r.slot = 9'(i + 1);
          r.gen = gen_of[i];
          if (mode == MODE_REGISTER) begin
            anch[i] = 1; r.ok = 1; r.key = k;
          end else if (leases[i] >= LEASE_MAX) begin
            r.err = ERR_LEASE_OVF;
          end else begin
            leases[i]++; r.ok = 1; r.key = k;
          end
        end else if (free_top == 0 && used_mark >= SLOTS) begin
          r.err = ERR_FULL;
        end else begin
          if (free_top > 0) begin
            free_top--;
            i = free_list[free_top];
          end else begin
            i = used_mark;
            used_mark++;
            gen_of[i] = domain;
          end
          key_of[i] = k;
          leases[i] = (mode == MODE_BORROW) ? 1 : 0;
          occ[i] = 1; alive[i] = 1; anch[i] = (mode == MODE_REGISTER);
          live_total++;
          step_revision();
          r.ok = 1; r.key = k; r.slot = 9'(i + 1); r.gen = gen_of[i];
        end
      end else if (mode == MODE_RESOLVE || mode == MODE_RELEASE || mode == MODE_REL_LEASE) begin
        r.slot = hslot;
        r.gen = hgen;
        if (hslot == 0 || hgen == 0 || hslot > used_mark) begin
          r.err = ERR_HANDLE;
        end else begin
          i = hslot - 1;
          if (gen_of[i] != hgen) r.err = ERR_GEN;
          else if (mode == MODE_RESOLVE) begin
            if (!occ[i]) r.err = ERR_STALE;
            else if (!alive[i]) r.err = ERR_OBJECT;
            else begin r.ok = 1; r.key = key_of[i]; end
          end else if (mode == MODE_RELEASE) begin
            if (!occ[i]) r.err = ERR_STALE;
            else begin
              r.ok = 1;
              r.key = alive[i] ? key_of[i] : 32'd0;
              free_entry(i);
            end
          end else begin
            if (!occ[i] || leases[i] == 0) r.err = ERR_NO_LEASE;
            else begin
              r.ok = 1;
              r.key = alive[i] ? key_of[i] : 32'd0;
              leases[i]--;
              if (leases[i] == 0 && !anch[i]) free_entry(i);
            end
          end
        end
      end else if (mode == MODE_CLEAR) begin
        for (int j = 0; j < SLOTS; j++) begin
          occ[j] = 0; anch[j] = 0; alive[j] = 0;
        end
        free_top = 0; used_mark = 0; live_total = 0;
        domain = gen_after(domain);
        step_revision();
        r.ok = 1;
      end else if (mode == MODE_DESTROYED) begin
        for (int j = 0; j < used_mark; j++)
          if (occ[j] && key_of[j] == k) alive[j] = 0;
        r.ok = 1;
      end
      r.rev = rev;
      r.live = 9'(live_total);
      awaited.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", got);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp ok=%0d err=%0d slot=%0d gen=%h key=%h rev=%0d live=%0d\n",
                    "          got ok=%0d err=%0d slot=%0d gen=%h key=%h rev=%0d live=%0d"},
                   want.ok, want.err, want.slot, want.gen, want.key, want.rev, want.live,
                   got.ok, got.err, got.slot, got.gen, got.key, got.rev, got.live);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  in_tdata;   // object_id, object_alive, handle_slot, handle_generation
  logic [2:0]   in_tuser;   // mode
  logic         out_tvalid;
  logic         out_tready;
  logic [151:0] out_tdata;  // out_slot, out_generation, out_object_id, revision, live_count
  logic [3:0]   out_tuser;  // succeeded, error_code

  handle_table_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit pressure_on = 0;
  int unsigned rx_cycle = 0;

  generational_handle_table DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (pressure_on && (rx_cycle % 1000) < 400) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    table_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok   = out_tuser[0];
      got.err  = out_tuser[3:1];
      got.slot = out_tdata[8:0];
      got.gen  = out_tdata[40:9];
      got.key  = out_tdata[72:41];
      got.rev  = out_tdata[136:73];
      got.live = out_tdata[145:137];
      sb.check_result(got);
    end
  end

  // valid goes low at the accepting edge and rises no earlier than the next edge
  task automatic send_op(logic [2:0] mode, logic [31:0] k, logic live_obj,
                         logic [8:0] hslot, logic [31:0] hgen);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'd0, hgen, hslot, live_obj, k};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    sb.note_input(mode, k, live_obj, hslot, hgen);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_first_generation(logic [31:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.set_first_generation(v);
    cfg_valid <= 1'b0;
  endtask

  // current-generation handle of a used slot, or slot 1 generation 1 if nothing is used yet
  task automatic handle_op(logic [2:0] mode, int unsigned idx);
    if (sb.used_mark == 0) send_op(mode, 0, 1, 9'd1, 32'd1);
    else send_op(mode, 0, 1, 9'(idx + 1), sb.gen_of[idx]);
  endtask

  task automatic random_op();
    int r;
    logic [31:0] k;
    logic [8:0] hs;
    logic [31:0] hg;
    int unsigned idx;
    r = $urandom_range(99);
    k = ($urandom_range(9) == 0) ? $urandom : 32'h100 + 32'($urandom_range(23));
    if (r < 32) begin
      send_op($urandom_range(1) ? MODE_BORROW : MODE_REGISTER, k,
              1'($urandom_range(19) != 0), 9'($urandom), $urandom);
    end else if (r < 72) begin
      idx = (sb.used_mark == 0) ? 0 : $urandom_range(sb.used_mark - 1);
      hs = 9'(idx + 1);
      hg = (sb.used_mark == 0) ? 32'd1 : sb.gen_of[idx];
      case ($urandom_range(19))
        0: hs = 0;
        1: hg = 0;
        2: hs = 9'($urandom);
        3: hg = $urandom;
        4: hg = hg + 1;
        default: ;
      endcase
      send_op(3'(MODE_RESOLVE + 3'($urandom_range(2))), $urandom, 1'($urandom), hs, hg);
    end else if (r < 75) begin
      send_op(MODE_CLEAR, $urandom, 1'($urandom), 9'($urandom), $urandom);
    end else if (r < 83) begin
      send_op(MODE_DESTROYED, k, 1'($urandom), 9'($urandom), $urandom);
    end else if (r < 86) begin
      send_op(MODE_UNUSED, $urandom, 1'($urandom), 9'($urandom), $urandom);
    end else begin
      send_op(3'($urandom_range(7)), k, 1'($urandom), 9'($urandom), $urandom);
    end
  endtask

  initial begin
    sb = new();
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // basic operations and error paths
    send_op(MODE_REGISTER, 32'hA, 0, 0, 0);
    send_op(MODE_REGISTER, 32'hA, 1, 0, 0);
    send_op(MODE_REGISTER, 32'hA, 1, 0, 0);
    send_op(MODE_BORROW, 32'hA, 1, 0, 0);
    send_op(MODE_BORROW, 32'hFFFF_FFFF, 1, 0, 0);
    send_op(MODE_BORROW, 32'h0, 1, 0, 0);
    handle_op(MODE_RESOLVE, 0);
    send_op(MODE_RESOLVE, 0, 0, 9'd1, 32'd7);
    send_op(MODE_RESOLVE, 0, 0, 9'd0, 32'd1);
    send_op(MODE_RESOLVE, 0, 0, 9'd1, 32'd0);
    send_op(MODE_RESOLVE, 0, 0, 9'h1FF, 32'hFFFF_FFFF);
    handle_op(MODE_REL_LEASE, 0);
    handle_op(MODE_REL_LEASE, 0);
    send_op(MODE_DESTROYED, 32'hA, 0, 0, 0);
    handle_op(MODE_RESOLVE, 0);
    send_op(MODE_REGISTER, 32'hA, 1, 0, 0);
    handle_op(MODE_RELEASE, 0);
    send_op(MODE_RELEASE, 0, 0, 9'd1, 32'd1);
    handle_op(MODE_REL_LEASE, 1);
    send_op(MODE_REGISTER, 32'hB, 1, 0, 0);
    send_op(MODE_UNUSED, 32'hFFFF_FFFF, 1, 9'h1FF, 32'hFFFF_FFFF);
    send_op(MODE_CLEAR, 0, 0, 0, 0);
    send_op(MODE_RESOLVE, 0, 0, 9'd1, 32'd2);

    // generation wrap of a slot and of the domain
    write_first_generation(32'hFFFF_FFFF);
    send_op(MODE_CLEAR, 0, 0, 0, 0);
    write_first_generation(32'hFFFF_FFFF);
    send_op(MODE_REGISTER, 32'h5, 1, 0, 0);
    handle_op(MODE_RELEASE, 0);
    send_op(MODE_REGISTER, 32'h6, 1, 0, 0);
    send_op(MODE_REGISTER, 32'h7, 1, 0, 0);
    send_op(MODE_CLEAR, 0, 0, 0, 0);
    send_op(MODE_REGISTER, 32'h8, 1, 0, 0);
    write_first_generation(32'd0);
    send_op(MODE_CLEAR, 0, 0, 0, 0);
    send_op(MODE_REGISTER, 32'h9, 1, 0, 0);

    // full table, then pop from the free stack
    for (int i = 0; i < SLOTS; i++) send_op(MODE_REGISTER, 32'h1000 + i, 1, 0, 0);
    send_op(MODE_BORROW, 32'h5000, 1, 0, 0);
    handle_op(MODE_RELEASE, 17);
    handle_op(MODE_RELEASE, 200);
    send_op(MODE_REGISTER, 32'h5001, 1, 0, 0);
    send_op(MODE_BORROW, 32'h5002, 1, 0, 0);
    send_op(MODE_BORROW, 32'h5003, 1, 0, 0);
    send_op(MODE_CLEAR, 0, 0, 0, 0);

    write_first_generation(32'd1);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; pressure_on = 1; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      for (int n = 0; n < 300; n++) random_op();
      pressure_on = 0;
      write_first_generation((ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? $urandom : 32'd1);
    end

    drain_results();
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("tb_generational_handle_table: clean");
    else
      $display("tb_generational_handle_table: errors");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("tb_generational_handle_table: errors");
    $finish;
  end

endmodule
